// ===== rtl/s337d_pkg.sv =====
// shared constants and types for the smpte 337 burst deframer
`default_nettype none
package s337d_pkg;

    localparam int BUFFER_BYTES     = 16384;
    localparam int OFFSET_FIELD_MAX = 16383;
    localparam int OFFSET_LIMIT     = (BUFFER_BYTES - 1 > OFFSET_FIELD_MAX) ?
                                      OFFSET_FIELD_MAX : BUFFER_BYTES - 1;
    localparam int OFS_W            = 14;
    localparam int TYPE_W           = 5;
    localparam int MODE_W           = 2;
    localparam int BITS_W           = 16;
    localparam int LEFT_W           = BITS_W - 3;

    localparam int WIN_DEPTH = 8;
    localparam int WIN_CW    = $clog2(WIN_DEPTH + 1);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    typedef logic [OFS_W-1:0] offset_t;

    localparam offset_t OFS_LIMIT = OFS_W'(OFFSET_LIMIT);

    // preamble bytes in stream order
    localparam logic [7:0] PA_BYTE0 = 8'hF8;
    localparam logic [7:0] PA_BYTE1 = 8'h72;
    localparam logic [7:0] PB_BYTE0 = 8'h4E;
    localparam logic [7:0] PB_BYTE1 = 8'h1F;

    localparam logic [TYPE_W-1:0] TYPE_AC3 = 5'd1;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic [7:0] data;
        offset_t    offset;
    } byte_item_t;

    typedef struct packed {
        logic              kind;
        logic [7:0]        data_byte;
        logic [MODE_W-1:0] data_mode;
        logic [TYPE_W-1:0] data_type;
        logic [BITS_W-1:0] bit_count;
        offset_t           sync_offset;
        logic              last;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/s337d_front.sv =====
// front end: takes audio words, splits them into stream bytes with buffer offsets
`default_nettype none
module s337d_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [s337d_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,
    input  wire logic                          q_full,
    output logic                               q_push,
    output s337d_pkg::byte_item_t              q_item
);
    import s337d_pkg::*;

    logic        busy_reg, busy_next;
    logic        phase_reg, phase_next;
    logic [15:0] word_reg, word_next;
    logic        fs_reg, fs_next;
    offset_t     pos_reg, pos_next;
    offset_t     cur_pos;
    logic        accept;

    always_comb begin
        q_push   = busy_reg && !q_full;
        s_tready = !busy_reg || (phase_reg && q_push);
        accept   = s_tvalid && s_tready;

        // a new buffer restarts the offset at its first byte
        cur_pos        = (!phase_reg && fs_reg) ? '0 : pos_reg;
        q_item.data    = phase_reg ? word_reg[7:0] : word_reg[15:8];
        q_item.offset  = cur_pos;

        busy_next  = busy_reg;
        phase_next = phase_reg;
        word_next  = word_reg;
        fs_next    = fs_reg;
        pos_next   = pos_reg;
        if (q_push) begin
            pos_next   = (cur_pos < OFS_LIMIT) ? cur_pos + 1'b1 : OFS_LIMIT;
            phase_next = !phase_reg;
        end
        if (accept) begin
            busy_next = 1'b1;
            word_next = s_tdata[31:16];
            fs_next   = s_tuser;
        end else if (q_push && phase_reg) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            pos_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
        word_reg <= word_next;
        fs_reg   <= fs_next;
    end

    a_phase_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> !phase_reg)
        else $error("second byte pending without a word");

    a_pos_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= OFS_LIMIT)
        else $error("byte offset beyond limit");

    a_accept_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && busy_reg) |-> (phase_reg && q_push))
        else $error("word taken before previous word fully queued");

endmodule
`default_nettype wire

// ===== rtl/s337d_fifo.sv =====
// short byte queue between the front end and the burst parser
`default_nettype none
module s337d_fifo (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire s337d_pkg::byte_item_t push_item,
    output logic                       full,
    input  wire logic                  pop,
    output s337d_pkg::byte_item_t      pop_item,
    output logic                       not_empty
);
    import s337d_pkg::*;

    byte_item_t           mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;

    always_comb begin
        full      = (count_reg == FIFO_CW'(FIFO_DEPTH));
        not_empty = (count_reg != '0);
        pop_item  = mem_reg[rd_ptr_reg];

        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_count_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule
`default_nettype wire

// ===== rtl/s337d_back.sv =====
// burst parser: sliding preamble window, header and payload results, output register
`default_nettype none
module s337d_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [s337d_pkg::TYPE_W-1:0] cfg_wdata,
    input  wire logic                       q_valid,
    input  wire s337d_pkg::byte_item_t      q_item,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output s337d_pkg::result_t              m_result
);
    import s337d_pkg::*;

    logic [7:0]         win_reg [WIN_DEPTH];
    logic [7:0]         win_next [WIN_DEPTH];
    offset_t            ofs_reg [WIN_DEPTH];
    offset_t            ofs_next [WIN_DEPTH];
    logic [WIN_CW-1:0]  cnt_reg, cnt_next;
    logic               in_payload_reg, in_payload_next;
    logic [LEFT_W-1:0]  left_reg, left_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [TYPE_W-1:0]  type_reg, type_next;
    logic [BITS_W-1:0]  bits_reg, bits_next;
    logic [TYPE_W-1:0]  accept_type_reg, accept_type_next;
    logic               out_valid_reg, out_valid_next;
    result_t            res_reg, res_next;

    logic [7:0]         nwin [WIN_DEPTH];
    offset_t            nofs [WIN_DEPTH];
    logic               match;
    logic [BITS_W-1:0]  new_bits;
    logic [LEFT_W-1:0]  new_bytes;
    logic               produce;

    always_comb begin
        q_pop = q_valid && (!out_valid_reg || m_tready);

        for (int i = 0; i < WIN_DEPTH; i++) begin
            nwin[i] = (i == WIN_DEPTH - 1) ? q_item.data   : win_reg[(i + 1) % WIN_DEPTH];
            nofs[i] = (i == WIN_DEPTH - 1) ? q_item.offset : ofs_reg[(i + 1) % WIN_DEPTH];
        end

        // full window once this byte makes eight since the last clear
        match = (cnt_reg >= WIN_CW'(WIN_DEPTH - 1)) &&
                (nwin[0] == PA_BYTE0) && (nwin[1] == PA_BYTE1) &&
                (nwin[2] == PB_BYTE0) && (nwin[3] == PB_BYTE1) &&
                (nwin[5][TYPE_W-1:0] == accept_type_reg);
        new_bits  = {nwin[6], nwin[7]};
        new_bytes = new_bits[BITS_W-1:3];

        accept_type_next = cfg_we ? cfg_wdata : accept_type_reg;
        win_next         = win_reg;
        ofs_next         = ofs_reg;
        cnt_next         = cnt_reg;
        in_payload_next  = in_payload_reg;
        left_next        = left_reg;
        mode_next        = mode_reg;
        type_next        = type_reg;
        bits_next        = bits_reg;
        produce          = 1'b0;
        res_next         = res_reg;

        if (q_pop) begin
            if (in_payload_reg) begin
                produce              = 1'b1;
                res_next.kind        = KIND_PAYLOAD;
                res_next.data_byte   = q_item.data;
                res_next.data_mode   = mode_reg;
                res_next.data_type   = type_reg;
                res_next.bit_count   = bits_reg;
                res_next.sync_offset = '0;
                res_next.last        = (left_reg <= LEFT_W'(1));
                if (left_reg <= LEFT_W'(1)) begin
                    in_payload_next = 1'b0;
                    left_next       = '0;
                    cnt_next        = '0;
                end else begin
                    left_next = left_reg - 1'b1;
                end
            end else begin
                win_next = nwin;
                ofs_next = nofs;
                cnt_next = (cnt_reg >= WIN_CW'(WIN_DEPTH)) ?
                           WIN_CW'(WIN_DEPTH) : cnt_reg + 1'b1;
                if (match) begin
                    produce   = 1'b1;
                    cnt_next  = '0;
                    mode_next = nwin[5][TYPE_W+MODE_W-1:TYPE_W];
                    type_next = nwin[5][TYPE_W-1:0];
                    bits_next = new_bits;
                    if (new_bytes != '0) begin
                        in_payload_next = 1'b1;
                        left_next       = new_bytes;
                    end
                    res_next.kind        = KIND_HEADER;
                    res_next.data_byte   = '0;
                    res_next.data_mode   = nwin[5][TYPE_W+MODE_W-1:TYPE_W];
                    res_next.data_type   = nwin[5][TYPE_W-1:0];
                    res_next.bit_count   = new_bits;
                    res_next.sync_offset = nofs[0];
                    res_next.last        = (new_bytes == '0);
                end
            end
        end

        out_valid_next = produce ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

        m_tvalid = out_valid_reg;
        m_result = res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg         <= '0;
            in_payload_reg  <= 1'b0;
            left_reg        <= '0;
            accept_type_reg <= TYPE_AC3;
            out_valid_reg   <= 1'b0;
        end else begin
            cnt_reg         <= cnt_next;
            in_payload_reg  <= in_payload_next;
            left_reg        <= left_next;
            accept_type_reg <= accept_type_next;
            out_valid_reg   <= out_valid_next;
        end
        win_reg  <= win_next;
        ofs_reg  <= ofs_next;
        mode_reg <= mode_next;
        type_reg <= type_next;
        bits_reg <= bits_next;
        res_reg  <= res_next;
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= WIN_CW'(WIN_DEPTH))
        else $error("window count out of range");

    a_payload_left: assert property (@(posedge aclk) disable iff (!aresetn)
        in_payload_reg |-> (left_reg != '0))
        else $error("in payload with nothing left");

    a_payload_window: assert property (@(posedge aclk) disable iff (!aresetn)
        in_payload_reg |-> (cnt_reg == '0))
        else $error("window not empty during payload");

    a_header_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && res_reg.kind == KIND_HEADER && !res_reg.last) |-> in_payload_reg ||
        $past(in_payload_reg) || !$stable(res_reg))
        else $error("open header without payload to follow");

endmodule
`default_nettype wire

// ===== rtl/smpte337_burst_deframer.sv =====
// top level of the smpte 337 burst deframer
//
//  port group  dir  payload                                       meaning
//  s_*         in   tdata[31:0] sample_word, tuser frame_start   one audio word
//  m_*         out  tdata see port, tuser kind, tlast last        header or payload byte
//  cfg_*       in   cfg_wdata[4:0] accept_type                    burst type to lock onto
//
// each word carries two stream bytes; the parser takes one byte per cycle when nothing
// stalls, and the front end can take a new word as it queues the last byte of the one before.
// a four-entry byte queue sits between the word front end and the parser; a full
// output register or a full queue stalls only the side behind it.
// aresetn is synchronous, active low; accept_type resets to 1 (ac-3).
`default_nettype none
module smpte337_burst_deframer (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [s337d_pkg::TYPE_W-1:0]     cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [31:0] sample_word
    input  wire logic [s337d_pkg::IN_DATA_W-1:0]  s_tdata,
    // [0] frame_start
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [7:0] data_byte, [9:8] data_mode, [14:10] data_type, [30:15] bit_count,
    // [44:31] sync_offset, [47:45] zero
    output logic [s337d_pkg::OUT_DATA_W-1:0]      m_tdata,
    // [0] kind
    output logic                                  m_tuser,
    output logic                                  m_tlast
);
    import s337d_pkg::*;

    byte_item_t push_item;
    byte_item_t pop_item;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;
    result_t    result;

    s337d_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    s337d_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .not_empty (q_valid)
    );

    s337d_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_item    (pop_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (result)
    );

    always_comb begin
        m_tdata = {3'b000, result.sync_offset, result.bit_count, result.data_type,
                   result.data_mode, result.data_byte};
        m_tuser = result.kind;
        m_tlast = result.last;
    end

endmodule
`default_nettype wire

// ===== dv/smpte337_burst_deframer_tb.sv =====
// self-checking testbench for the smpte 337 burst deframer: directed table, then random bursts
module smpte337_burst_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import s337d_pkg::*;

    localparam int DRAIN_CYCLES   = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_ROWS         = 22;

    typedef struct {
        logic [31:0] word;
        logic        fs;
        bit          typed;
        result_t     hdr;
    } stim_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [TYPE_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    smpte337_burst_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // deframer state as seen by the predictor
    logic [TYPE_W-1:0] accept_cfg = TYPE_AC3;
    logic [7:0]        win_byte [WIN_DEPTH];
    offset_t           win_ofs  [WIN_DEPTH];
    int                win_fill   = 0;
    bit                in_burst   = 1'b0;
    int                burst_left = 0;
    offset_t           next_pos   = '0;
    logic [MODE_W-1:0] cur_mode   = '0;
    logic [TYPE_W-1:0] cur_type   = '0;
    logic [BITS_W-1:0] cur_bits   = '0;

    result_t    burst_items_due [$];
    logic [7:0] pending_bytes [$];
    stim_row_t  directed_rows [N_ROWS];

    int error_count = 0;
    int words_sent  = 0;
    int fs_odds     = 24;
    bit force_fs    = 1'b0;
    bit stall_on    = 1'b1;
    int stall_left  = 0;
    int quiet_cycles = 0;

    function automatic result_t header_item(logic [MODE_W-1:0] mode, logic [TYPE_W-1:0] dtype,
                                            logic [BITS_W-1:0] bits, offset_t ofs,
                                            logic last);
        result_t r;
        r = '0;
        r.kind        = KIND_HEADER;
        r.data_mode   = mode;
        r.data_type   = dtype;
        r.bit_count   = bits;
        r.sync_offset = ofs;
        r.last        = last;
        return r;
    endfunction

    // one stream byte through the hunt / payload logic; returns number of items produced
    function automatic int deframe_byte(logic [7:0] b);
        offset_t here;
        result_t r;
        int      nbytes;
        here = next_pos;
        if (next_pos < OFS_LIMIT)
            next_pos = next_pos + 1'b1;
        r = '0;
        if (in_burst) begin
            r.kind      = KIND_PAYLOAD;
            r.data_byte = b;
            r.last      = (burst_left <= 1);
            if (r.last) begin
                in_burst   = 1'b0;
                burst_left = 0;
                win_fill   = 0;
            end else begin
                burst_left--;
            end
        end else begin
            win_byte[win_fill] = b;
            win_ofs[win_fill]  = here;
            win_fill++;
            if (win_fill < WIN_DEPTH)
                return 0;
            if (win_byte[0] != PA_BYTE0 || win_byte[1] != PA_BYTE1 ||
                win_byte[2] != PB_BYTE0 || win_byte[3] != PB_BYTE1 ||
                win_byte[5][4:0] != accept_cfg) begin
                for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                    win_byte[i] = win_byte[i+1];
                    win_ofs[i]  = win_ofs[i+1];
                end
                win_fill = WIN_DEPTH - 1;
                return 0;
            end
            cur_bits = {win_byte[6], win_byte[7]};
            cur_mode = win_byte[5][6:5];
            cur_type = win_byte[5][4:0];
            nbytes   = int'(cur_bits >> 3);
            win_fill = 0;
            if (nbytes > 0) begin
                in_burst   = 1'b1;
                burst_left = nbytes;
            end
            r.kind        = KIND_HEADER;
            r.sync_offset = win_ofs[0];
            r.last        = (nbytes == 0);
        end
        r.data_mode = cur_mode;
        r.data_type = cur_type;
        r.bit_count = cur_bits;
        burst_items_due.push_back(r);
        return 1;
    endfunction

    function automatic int deframe_word(logic [31:0] word, logic fs);
        int n;
        if (fs)
            next_pos = '0;
        n = deframe_byte(word[31:24]);
        n += deframe_byte(word[23:16]);
        return n;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    task automatic push_word(logic [31:0] word, logic fs, bit typed, result_t typed_hdr);
        int produced;
        @(negedge aclk);
        if (stall_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= fs;
        do @(posedge aclk); while (s_tready !== 1'b1);
        produced = deframe_word(word, fs);
        // directed rows with a hand-written header replace what the predictor made
        if (typed) begin
            repeat (produced) void'(burst_items_due.pop_back());
            burst_items_due.push_back(typed_hdr);
        end
        words_sent++;
    endtask

    task automatic flush_pairs();
        logic [7:0] hi;
        logic [7:0] lo;
        logic       fs;
        while (pending_bytes.size() >= 2) begin
            hi = pending_bytes.pop_front();
            lo = pending_bytes.pop_front();
            fs = force_fs || (fs_odds != 0 && $urandom_range(1, fs_odds) == 1);
            force_fs = 1'b0;
            push_word({hi, lo, 16'($urandom)}, fs, 1'b0, '0);
        end
    endtask

    task automatic finish_bytes();
        if (pending_bytes.size() % 2 == 1)
            pending_bytes.push_back(8'($urandom));
        flush_pairs();
    endtask

    task automatic queue_burst(logic [TYPE_W-1:0] dtype, logic [BITS_W-1:0] bits,
                               logic [MODE_W-1:0] mode);
        pending_bytes.push_back(PA_BYTE0);
        pending_bytes.push_back(PA_BYTE1);
        pending_bytes.push_back(PB_BYTE0);
        pending_bytes.push_back(PB_BYTE1);
        pending_bytes.push_back(8'($urandom));
        pending_bytes.push_back({1'($urandom), mode, dtype});
        pending_bytes.push_back(bits[15:8]);
        pending_bytes.push_back(bits[7:0]);
        repeat (int'(bits >> 3)) pending_bytes.push_back(8'($urandom));
    endtask

    task automatic run_traffic(int n_words);
        int                target;
        logic [7:0]        pre [4];
        logic [TYPE_W-1:0] dtype;
        logic [BITS_W-1:0] bits;
        target = words_sent + n_words;
        while (words_sent < target) begin
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 12)) pending_bytes.push_back(8'($urandom));
                end
                1: begin
                    // preamble with one byte spoiled
                    pre = '{PA_BYTE0, PA_BYTE1, PB_BYTE0, PB_BYTE1};
                    pre[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
                    foreach (pre[i]) pending_bytes.push_back(pre[i]);
                    repeat (4) pending_bytes.push_back(8'($urandom));
                end
                default: begin
                    repeat ($urandom_range(0, 3)) pending_bytes.push_back(8'($urandom));
                    dtype = ($urandom_range(0, 3) == 0) ? 5'($urandom) : accept_cfg;
                    bits  = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 7))
                                                         : 16'($urandom_range(8, 160));
                    queue_burst(dtype, bits, 2'($urandom));
                end
            endcase
            flush_pairs();
        end
        finish_bytes();
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (burst_items_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_accept_type(logic [TYPE_W-1:0] v);
        settle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        accept_cfg = v;
    endtask

    // receiver back-pressure in random bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (stall_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : out_monitor
        result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (burst_items_due.size() == 0) begin
                $error("result item with nothing outstanding: tdata 0x%0h", m_tdata);
                error_count++;
            end else begin
                want = burst_items_due.pop_front();
                check_field("kind", want.kind, m_tuser);
                check_field("data_byte", want.data_byte, m_tdata[7:0]);
                check_field("data_mode", want.data_mode, m_tdata[9:8]);
                check_field("data_type", want.data_type, m_tdata[14:10]);
                check_field("bit_count", want.bit_count, m_tdata[30:15]);
                check_field("sync_offset", want.sync_offset, m_tdata[44:31]);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        directed_rows = '{
            // empty burst right after reset, ac-3 accepted by default
            '{32'hF872_0000, 1'b1, 1'b0, '0},
            '{32'h4E1F_0000, 1'b0, 1'b0, '0},
            '{32'h0001_FFFF, 1'b0, 1'b0, '0},
            '{32'h0000_0000, 1'b0, 1'b1, header_item(2'd0, TYPE_AC3, 16'd0, 14'd0, 1'b1)},
            // mode 3, six payload bytes, new buffer in the middle of the payload
            '{32'hF872_FFFF, 1'b0, 1'b0, '0},
            '{32'h4E1F_A5A5, 1'b0, 1'b0, '0},
            '{32'h7F61_5A5A, 1'b0, 1'b0, '0},
            '{32'h0030_0000, 1'b0, 1'b1, header_item(2'd3, TYPE_AC3, 16'd48, 14'd8, 1'b0)},
            '{32'hABCD_1234, 1'b0, 1'b0, '0},
            '{32'h0102_FFFF, 1'b1, 1'b0, '0},
            '{32'hFF00_0000, 1'b0, 1'b0, '0},
            // wrong data type, window slides on
            '{32'hF872_0000, 1'b0, 1'b0, '0},
            '{32'h4E1F_0000, 1'b0, 1'b0, '0},
            '{32'h0002_0000, 1'b0, 1'b0, '0},
            '{32'h0008_0000, 1'b0, 1'b0, '0},
            // sync on an odd byte, header and its only payload byte in one word
            '{32'h00F8_FFFF, 1'b0, 1'b0, '0},
            '{32'h724E_0000, 1'b0, 1'b0, '0},
            '{32'h1F00_0000, 1'b0, 1'b0, '0},
            '{32'h0100_0000, 1'b0, 1'b0, '0},
            '{32'h0FAA_0000, 1'b0, 1'b0, '0},
            '{32'hFFFF_FFFF, 1'b1, 1'b0, '0},
            '{32'h0000_0000, 1'b0, 1'b0, '0}
        };

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            push_word(directed_rows[i].word, directed_rows[i].fs, directed_rows[i].typed,
                      directed_rows[i].hdr);

        set_accept_type(5'd0);
        run_traffic(130);
        set_accept_type(5'd31);
        run_traffic(130);

        // short bursts at the byte boundary, then a longer mode-3 burst and a 16-bit burst, in one buffer
        set_accept_type(5'($urandom));
        fs_odds  = 0;
        force_fs = 1'b1;
        queue_burst(accept_cfg, 16'h0000, 2'($urandom));
        queue_burst(accept_cfg, 16'd7, 2'd0);
        queue_burst(accept_cfg, 16'd8, 2'd3);
        queue_burst(accept_cfg, 16'd255, 2'd3);
        queue_burst(accept_cfg, 16'd16, 2'($urandom));
        finish_bytes();
        fs_odds = 24;

        set_accept_type(5'($urandom));
        run_traffic(130);
        set_accept_type(TYPE_AC3);
        run_traffic(50);
        stall_on = 1'b0;
        run_traffic(100);

        settle();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/s337d_pkg.sv
rtl/s337d_front.sv
rtl/s337d_fifo.sv
rtl/s337d_back.sv
rtl/smpte337_burst_deframer.sv
dv/smpte337_burst_deframer_tb.sv
